// ===== design/assert_macros.svh =====
// Assertion macros for the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/ffba_pkg.sv =====
package ffba_pkg;
	localparam int BufferBytesDef = 4096;
	localparam int MaxBlocksDef   = 32;
	localparam int OffW = 12;
	localparam int ReqW = 13;
	localparam int HdrW = 7;
	localparam logic [HdrW-1:0] HdrReset = 7'd24;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
	localparam logic [2:0] ST_NO_GAP    = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic            kind;
		logic [ReqW-1:0] request_bytes;
		logic [OffW-1:0] payload_offset;
	} req_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [OffW-1:0] granted_offset;
	} rsp_t;
endpackage

// ===== design/ffba_ram.sv =====
module ffba_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/first_fit_block_allocator.sv =====
// First-fit block allocator.
// Usage: pulse start with req (kind, request_bytes, payload_offset) while busy
// is low. busy rises the next cycle and stays high until the result word
// appears on rsp for one cycle, marked by done; the receiver cannot stall it.
// Allocate scans the block table in address order for the first gap that
// holds header_bytes + request_bytes; free scans for the matching payload
// offset. The table lives in one synchronous RAM (start and length packed,
// one read and one write port); after a hit the entries above the slot are
// shifted one place up (insert) or down (remove), one entry per cycle.
// Each entry visited takes a read state (S_READ) and a compare state (S_SCAN);
// each shift step moves one entry, plus one step to write the new entry on
// allocate. Requests refused at start go straight to S_DONE. A new word may be taken
// in the cycle the result is shown.
// Reset clears the block count and sets header_bytes to its default; the RAM
// needs no clearing pass since only entries below the count are used. The user
// must write header_bytes (APB address 0) only while the block is idle, unchecked.
module first_fit_block_allocator #(
	parameter int BUFFER_BYTES = ffba_pkg::BufferBytesDef,
	parameter int MAX_BLOCKS   = ffba_pkg::MaxBlocksDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ffba_pkg::req_t req,
	output logic           done,
	output ffba_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [1:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	`include "assert_macros.svh"
	import ffba_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int PW = $clog2(BUFFER_BYTES + 1) + 1; // position width, room for sums
	localparam int EW = 2 * PW;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_SHUP  = 6'b001000,
		S_SHDN  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t          state_q;
	logic [HdrW-1:0] hdr_q;
	logic [CW-1:0]   count_q;
	logic            kind_q;
	logic [PW-1:0]   len_q, off_q, prev_end_q;
	logic [CW-1:0]   idx_q;
	logic [EW-1:0]   carry_q;
	rsp_t            rsp_q;
	logic            done_q;

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [EW-1:0]   wdata, rdata;
	logic [PW-1:0]   rd_start, rd_len;

	ffba_ram #(.Width(EW), .Depth(MAX_BLOCKS)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	assign rd_start = rdata[EW-1:PW];
	assign rd_len   = rdata[PW-1:0];

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {{(32-HdrW){1'b0}}, hdr_q} : 32'd0;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	logic [PW-1:0] req_len, buf_sz;
	assign req_len = PW'(req.request_bytes) + PW'(hdr_q);
	assign buf_sz  = PW'(BUFFER_BYTES);

	// read address: current entry while scanning, one ahead while a free
	// compares and while shifting, so the next entry is read ahead of its use
	always_comb begin
		raddr = idx_q[AW-1:0];
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = carry_q;
		case (state_q)
			S_SCAN: begin
				if (kind_q == KIND_FREE) begin
					raddr = AW'(idx_q + CW'(1));
				end
			end
			S_SHUP: begin
				we = 1'b1;
				raddr = AW'(idx_q + CW'(1));
			end
			S_SHDN: begin
				we = 1'b1;
				waddr = AW'(idx_q - CW'(1));
				wdata = rdata;
				raddr = AW'(idx_q + CW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hdr_q   <= HdrReset;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_DONE);
			if (psel && penable && pwrite && paddr == 2'd0) begin
				hdr_q <= pwdata[HdrW-1:0];
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q     <= req.kind;
						len_q      <= req_len;
						off_q      <= PW'(req.payload_offset);
						prev_end_q <= '0;
						idx_q      <= '0;
						if (req.kind == KIND_ALLOC &&
							(req.request_bytes == '0 || req_len > buf_sz)) begin
							rsp_q   <= '{ST_BAD_SIZE, '0};
							state_q <= S_DONE;
						end else if (req.kind == KIND_ALLOC &&
							count_q >= CW'(MAX_BLOCKS)) begin
							rsp_q   <= '{ST_FULL, '0};
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							if (req.kind == KIND_ALLOC) begin
								carry_q <= {PW'(0), req_len};
								rsp_q   <= '{ST_OK, OffW'(hdr_q)};
								state_q <= S_SHUP;
							end else begin
								rsp_q   <= '{ST_NOT_FOUND, '0};
								state_q <= S_DONE;
							end
						end else begin
							rsp_q   <= '{ST_OK, '0};
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_SCAN; // RAM output valid next cycle
				end
				S_SCAN: begin
					if (kind_q == KIND_ALLOC) begin
						if (rd_start >= prev_end_q && rd_start - prev_end_q >= len_q) begin
							carry_q <= {prev_end_q, len_q};
							rsp_q.granted_offset <= OffW'(prev_end_q + PW'(hdr_q));
							state_q <= S_SHUP;
						end else if (idx_q + CW'(1) == count_q) begin
							if (rd_start + rd_len <= buf_sz &&
								buf_sz - (rd_start + rd_len) >= len_q) begin
								carry_q <= {rd_start + rd_len, len_q};
								rsp_q.granted_offset <=
									OffW'(rd_start + rd_len + PW'(hdr_q));
								idx_q <= count_q;
								state_q <= S_SHUP;
							end else begin
								rsp_q.status <= ST_NO_GAP;
								state_q <= S_DONE;
							end
						end else begin
							prev_end_q <= rd_start + rd_len;
							idx_q <= idx_q + CW'(1);
							state_q <= S_READ;
						end
					end else begin
						if (rd_start + PW'(hdr_q) == off_q) begin
							// last entry: just drop it, else close the table
							if (idx_q + CW'(1) == count_q) begin
								count_q <= count_q - CW'(1);
								state_q <= S_DONE;
							end else begin
								idx_q <= idx_q + CW'(1);
								state_q <= S_SHDN;
							end
						end else if (idx_q + CW'(1) == count_q) begin
							rsp_q.status <= ST_NOT_FOUND;
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + CW'(1);
							state_q <= S_READ;
						end
					end
				end
				S_SHUP: begin
					// write carried entry at idx, pick up old entry there
					if (idx_q == count_q) begin
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end else begin
						carry_q <= rdata;
						idx_q <= idx_q + CW'(1);
					end
				end
				S_SHDN: begin
					if (idx_q + CW'(1) == count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CHK_IMPL(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE, "result outside idle")
	`CHK_IMPL(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(MAX_BLOCKS), "count overflow")
	`CHK_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "start not taken")
endmodule
